// File: rtl/i2ctbe_pkg.sv
package i2ctbe_pkg;

    typedef struct packed {
        logic       mode;
        logic       scl_level;
        logic       sda_level;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       sda_drive_low;
        logic       scl_hold_low;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [2:0] bus_event;
        logic [7:0] tx_crc;
        logic [4:0] tx_free;
    } out_item_t;

    // Bus event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_WRITE    = 3'd1;
    localparam logic [2:0] EV_READ     = 3'd2;
    localparam logic [2:0] EV_STOP     = 3'd3;
    localparam logic [2:0] EV_NACK_END = 3'd4;
    localparam logic [2:0] EV_OVERFLOW = 3'd5;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam logic [0:0] REG_OWN_ADDRESS = 1'd0;
    localparam logic [0:0] REG_PAUSE_BYTE  = 1'd1;

    localparam logic [6:0] OWN_ADDRESS_RESET = 7'd8;
    localparam logic [7:0] CRC_POLY          = 8'h8C;
    localparam logic [7:0] EMPTY_READ_BYTE   = 8'hFF;

    typedef enum logic [3:0] {
        PH_IDLE            = 4'd0,
        PH_A_WAIT_LOW      = 4'd1,
        PH_A_WAIT_HIGH     = 4'd2,
        PH_A_HIGH          = 4'd3,
        PH_AK_WAIT_HIGH    = 4'd4,
        PH_AK_HIGH         = 4'd5,
        PH_R_WAIT_LOW      = 4'd6,
        PH_R_WAIT_HIGH     = 4'd7,
        PH_R_ACK_WAIT_LOW  = 4'd8,
        PH_R_ACK_WAIT_HIGH = 4'd9,
        PH_W_WAIT_HIGH     = 4'd10,
        PH_W_HIGH          = 4'd11,
        PH_W_ACK_WAIT_HIGH = 4'd12,
        PH_W_ACK_HIGH      = 4'd13
    } phase_t;

    typedef struct packed {
        logic       empty;
        logic [7:0] head_data;
    } txq_status_t;

    typedef struct packed {
        logic       sda_drive_low;
        logic       scl_hold_low;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [2:0] bus_event;
    } link_result_t;

    // Reflected CRC-8, one byte at a time.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/i2ctbe_txq.sv
module i2ctbe_txq #(
    parameter int TX_DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [7:0]              push_data,
    input  logic                    pop,
    output i2ctbe_pkg::txq_status_t status,
    output logic                    overflow,
    output logic [7:0]              crc_next,
    output logic [4:0]              free_next
);
    import i2ctbe_pkg::*;

    localparam int PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int CNT_W = $clog2(TX_DEPTH + 1);

    logic [7:0]       mem [TX_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       crc_reg;
    logic [7:0]       head_data_reg;
    logic             full;
    logic             do_push;
    logic [CNT_W+4:0] free_wide;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        full       = (count_reg == CNT_W'(TX_DEPTH));
        do_push    = push && !full;
        overflow   = push && full;
        tail_next  = do_push ? ptr_inc(tail_reg) : tail_reg;
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
        crc_next  = do_push ? crc8_update(crc_reg, push_data) : crc_reg;
        free_wide = (CNT_W + 5)'(TX_DEPTH) - (CNT_W + 5)'(count_next);
        free_next = free_wide[4:0];
    end

    assign status.empty     = (count_reg == '0);
    assign status.head_data = head_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            crc_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // The read port always fetches the entry that will be at the head next cycle,
    // with a bypass when that entry is being written now.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (do_push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

endmodule

// File: rtl/i2ctbe_link.sv
module i2ctbe_link (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     scl,
    input  logic                     sda,
    input  logic [6:0]               own_address,
    input  logic [7:0]               pause_byte,
    input  i2ctbe_pkg::txq_status_t  q_status,
    output logic                     pop,
    output i2ctbe_pkg::link_result_t result
);
    import i2ctbe_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic       read_dir_reg, read_dir_next;
    logic       drv_sda_reg, drv_sda_next;
    logic       drv_scl_reg, drv_scl_next;
    logic [7:0] read_byte;
    logic       read_pop;
    logic [3:0] bit_count_inc;

    always_comb
    begin
        if (pause_byte != 8'd0)
        begin
            read_byte = pause_byte;
            read_pop  = 1'b0;
        end
        else if (q_status.empty)
        begin
            read_byte = EMPTY_READ_BYTE;
            read_pop  = 1'b0;
        end
        else
        begin
            read_byte = q_status.head_data;
            read_pop  = 1'b1;
        end
    end

    assign bit_count_inc = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        read_dir_next  = read_dir_reg;
        drv_sda_next   = drv_sda_reg;
        drv_scl_next   = drv_scl_reg;
        pop            = 1'b0;
        result.rx_valid  = 1'b0;
        result.rx_data   = 8'd0;
        result.bus_event = EV_NONE;

        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!sda && scl)
                    begin
                        phase_next     = PH_A_WAIT_LOW;
                        shift_next     = 8'd0;
                        bit_count_next = 4'd0;
                        drv_sda_next   = 1'b0;
                        drv_scl_next   = 1'b0;
                    end
                end
                PH_A_WAIT_LOW:
                begin
                    if (!scl)
                    begin
                        phase_next = PH_A_WAIT_HIGH;
                    end
                end
                PH_A_WAIT_HIGH, PH_W_WAIT_HIGH:
                begin
                    drv_scl_next = 1'b0;
                    if (scl)
                    begin
                        shift_next     = {shift_reg[6:0], sda};
                        bit_count_next = bit_count_inc;
                        phase_next     = (phase_reg == PH_A_WAIT_HIGH) ? PH_A_HIGH : PH_W_HIGH;
                    end
                end
                PH_A_HIGH, PH_W_HIGH:
                begin
                    if (scl)
                    begin
                        // SDA moving while SCL is high: rising is a stop, falling a start.
                        if (shift_reg[0] != sda)
                        begin
                            drv_sda_next = 1'b0;
                            drv_scl_next = 1'b0;
                            if (sda)
                            begin
                                phase_next       = PH_IDLE;
                                result.bus_event = EV_STOP;
                            end
                            else
                            begin
                                phase_next     = PH_A_WAIT_LOW;
                                shift_next     = 8'd0;
                                bit_count_next = 4'd0;
                            end
                        end
                    end
                    else if (!bit_count_reg[3])
                    begin
                        phase_next = (phase_reg == PH_A_HIGH) ? PH_A_WAIT_HIGH : PH_W_WAIT_HIGH;
                    end
                    else if (phase_reg == PH_W_HIGH)
                    begin
                        drv_sda_next = 1'b1;
                        phase_next   = PH_W_ACK_WAIT_HIGH;
                    end
                    else if (shift_reg[7:1] == own_address)
                    begin
                        read_dir_next    = shift_reg[0];
                        result.bus_event = shift_reg[0] ? EV_READ : EV_WRITE;
                        drv_sda_next     = 1'b1;
                        phase_next       = PH_AK_WAIT_HIGH;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_AK_WAIT_HIGH:
                begin
                    if (scl)
                    begin
                        phase_next = PH_AK_HIGH;
                    end
                end
                PH_AK_HIGH:
                begin
                    if (!scl)
                    begin
                        drv_sda_next   = 1'b0;
                        drv_scl_next   = 1'b1;
                        bit_count_next = 4'd0;
                        if (read_dir_reg)
                        begin
                            shift_next = read_byte;
                            pop        = read_pop;
                            phase_next = PH_R_WAIT_LOW;
                        end
                        else
                        begin
                            shift_next = 8'd0;
                            phase_next = PH_W_WAIT_HIGH;
                        end
                    end
                end
                PH_R_WAIT_LOW:
                begin
                    if (!scl)
                    begin
                        drv_sda_next = !shift_reg[~bit_count_reg[2:0]];
                        drv_scl_next = 1'b0;
                        phase_next   = PH_R_WAIT_HIGH;
                    end
                end
                PH_R_WAIT_HIGH:
                begin
                    if (scl)
                    begin
                        bit_count_next = bit_count_inc;
                        phase_next = bit_count_inc[3] ? PH_R_ACK_WAIT_LOW : PH_R_WAIT_LOW;
                    end
                end
                PH_R_ACK_WAIT_LOW:
                begin
                    if (!scl)
                    begin
                        drv_sda_next = 1'b0;
                        phase_next   = PH_R_ACK_WAIT_HIGH;
                    end
                end
                PH_R_ACK_WAIT_HIGH:
                begin
                    if (scl)
                    begin
                        if (!sda)
                        begin
                            shift_next     = read_byte;
                            pop            = read_pop;
                            bit_count_next = 4'd0;
                            phase_next     = PH_R_WAIT_LOW;
                        end
                        else
                        begin
                            result.bus_event = EV_NACK_END;
                            phase_next       = PH_IDLE;
                        end
                    end
                end
                PH_W_ACK_WAIT_HIGH:
                begin
                    if (scl)
                    begin
                        phase_next = PH_W_ACK_HIGH;
                    end
                end
                PH_W_ACK_HIGH:
                begin
                    if (!scl)
                    begin
                        drv_sda_next = 1'b0;
                        if (pause_byte == 8'd0)
                        begin
                            result.rx_valid = 1'b1;
                            result.rx_data  = shift_reg;
                        end
                        shift_next     = 8'd0;
                        bit_count_next = 4'd0;
                        phase_next     = PH_W_WAIT_HIGH;
                    end
                end
                default:
                begin
                    phase_next   = PH_IDLE;
                    drv_sda_next = 1'b0;
                    drv_scl_next = 1'b0;
                end
            endcase
        end

        result.sda_drive_low = drv_sda_next;
        result.scl_hold_low  = drv_scl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            read_dir_reg  <= 1'b0;
            drv_sda_reg   <= 1'b0;
            drv_scl_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            read_dir_reg  <= read_dir_next;
            drv_sda_reg   <= drv_sda_next;
            drv_scl_reg   <= drv_scl_next;
        end
    end

endmodule

// File: rtl/i2c_target_byte_engine_top.sv
// I2C target with a seven-bit address, fed one oversampled SCL/SDA sample or one
// transmit-queue push per request, with one result per request. A taken request waits
// in the input register until it is processed, and its result is registered in the
// output register, so requests are taken one per clock, set by the single registered
// pass through the bus sequencer and the queue, as long as the output is not stalled.
// The input stalls only while a finished result waits on a stalled output. The
// transmit queue is a TX_DEPTH-entry memory with one write and one registered read
// port; a running reflected CRC-8 covers every byte accepted into it.
module i2c_target_byte_engine_top #(
    parameter int TX_DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  i2ctbe_pkg::in_item_t                     in_data,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output i2ctbe_pkg::out_item_t                    out_data,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [i2ctbe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [7:0]                               cfg_data
);
    import i2ctbe_pkg::*;

    in_item_t     in_reg;
    logic         in_full_reg, in_full_next;
    out_item_t    out_reg, out_next;
    logic         out_valid_reg, out_valid_next;
    logic [6:0]   own_address_reg;
    logic [7:0]   pause_byte_reg;
    logic         advance;
    logic         accept;
    logic         step_pins;
    logic         push;
    logic         pop;
    logic         overflow;
    logic [7:0]   crc_next;
    logic [4:0]   free_next;
    txq_status_t  q_status;
    link_result_t link_res;

    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign step_pins = advance && !in_reg.mode;
    assign push      = advance && in_reg.mode;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    i2ctbe_link u_link (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step_pins),
        .scl         (in_reg.scl_level),
        .sda         (in_reg.sda_level),
        .own_address (own_address_reg),
        .pause_byte  (pause_byte_reg),
        .q_status    (q_status),
        .pop         (pop),
        .result      (link_res)
    );

    i2ctbe_txq #(
        .TX_DEPTH (TX_DEPTH)
    ) u_txq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_reg.tx_byte),
        .pop       (pop),
        .status    (q_status),
        .overflow  (overflow),
        .crc_next  (crc_next),
        .free_next (free_next)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        out_next.sda_drive_low = link_res.sda_drive_low;
        out_next.scl_hold_low  = link_res.scl_hold_low;
        out_next.rx_valid      = link_res.rx_valid;
        out_next.rx_data       = link_res.rx_data;
        if (in_reg.mode)
        begin
            out_next.bus_event = overflow ? EV_OVERFLOW : EV_NONE;
        end
        else
        begin
            out_next.bus_event = link_res.bus_event;
        end
        out_next.tx_crc  = crc_next;
        out_next.tx_free = free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            own_address_reg <= OWN_ADDRESS_RESET;
            pause_byte_reg  <= 8'd0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OWN_ADDRESS: own_address_reg <= cfg_data[6:0];
                    REG_PAUSE_BYTE:  pause_byte_reg  <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // A processed request always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("processed request produced no result");

    // The clock is never stretched while SDA is being pulled low.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.sda_drive_low && out_reg.scl_hold_low))
        else $error("SDA and SCL both driven low");

    // A received byte is never reported together with a bus event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.rx_valid) |-> (out_reg.bus_event == EV_NONE))
        else $error("received byte reported alongside a bus event");
`endif

endmodule
